// File: design/lru_write_back_page_cache_assert.svh
// Assertion macros shared by the page cache modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef LRU_WRITE_BACK_PAGE_CACHE_ASSERT_SVH
`define LRU_WRITE_BACK_PAGE_CACHE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LWBPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LWBPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lwbpc_pkg.sv
`timescale 1ns / 1ps

package lwbpc_pkg;

    localparam int SLOTS  = 2;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PAGE_W = 8;

    localparam logic [PAGE_W-1:0] RESET_PAGE_CFG = PAGE_W'(15);

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [PAGE_W-1:0] page_t;

    typedef enum logic [1:0] {
        KIND_READ       = 2'd0,
        KIND_WRITE      = 2'd1,
        KIND_MARK_DIRTY = 2'd2,
        KIND_FLUSH      = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_HIT          = 3'd0,
        ST_MISS         = 3'd1,
        ST_REJ_RESERVED = 3'd2,
        ST_REJ_RANGE    = 3'd3,
        ST_NONE         = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        CFG_RESERVED_PAGE = 1'b0,
        CFG_PAGE_LIMIT    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        kind_t kind;
        page_t page_id;
    } req_t;

    typedef struct packed {
        status_t status;
        logic    slot;
        logic    writeback;
        page_t   writeback_page;
        logic    fill;
        logic    last;
    } rsp_t;

endpackage

// File: design/lwbpc_req_if.sv
`timescale 1ns / 1ps

interface lwbpc_req_if;
    import lwbpc_pkg::*;

    logic  valid;
    logic  ready;
    kind_t kind;
    page_t page_id;

    modport source (output valid, output kind, output page_id, input ready);
    modport sink (input valid, input kind, input page_id, output ready);
endinterface

// File: design/lwbpc_rsp_if.sv
`timescale 1ns / 1ps

interface lwbpc_rsp_if;
    import lwbpc_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    logic    slot;
    logic    writeback;
    page_t   writeback_page;
    logic    fill;
    logic    last;

    modport source (
        output valid, output status, output slot, output writeback,
        output writeback_page, output fill, output last, input ready
    );
    modport sink (
        input valid, input status, input slot, input writeback,
        input writeback_page, input fill, input last, output ready
    );
endinterface

// File: design/lru_write_back_page_cache.sv
// A request is loaded into the request register when it is accepted; its result word
// is then loaded into the result register once that register is free or being drained.
// One read, write or mark-dirty request is taken per cycle while the response side
// does not stall; a flush holds the request register until no dirty slot is left.
// Reset (rst_n, asynchronous, active low) empties all slots, restores rank order
// and sets both configuration registers to 15; no clearing pass is needed.
`timescale 1ns / 1ps
`include "lru_write_back_page_cache_assert.svh"

module lru_write_back_page_cache (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  lwbpc_pkg::cfg_index_t  cfg_index,
    input  lwbpc_pkg::page_t       cfg_data,
    lwbpc_req_if.sink              req,
    lwbpc_rsp_if.source            rsp
);
    import lwbpc_pkg::*;

    page_t reserved_page_reg;
    page_t page_limit_reg;
    logic  req_valid_reg;
    req_t  req_reg;
    logic  rsp_valid_reg;
    rsp_t  rsp_reg;
    rsp_t  result;
    logic  step;
    logic  req_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_page_reg <= RESET_PAGE_CFG;
            page_limit_reg    <= RESET_PAGE_CFG;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_RESERVED_PAGE: reserved_page_reg <= cfg_data;
                CFG_PAGE_LIMIT:    page_limit_reg    <= cfg_data;
                default:           reserved_page_reg <= reserved_page_reg;
            endcase
        end
    end

    // The table steps whenever a request is held and the result register is free or being drained.
    assign step      = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req_done  = step && result.last;
    assign req.ready = !req_valid_reg || req_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                req_valid_reg <= req.valid;
            end
            if (step)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            req_reg <= '{kind: req.kind, page_id: req.page_id};
        end
        if (step)
        begin
            rsp_reg <= result;
        end
    end

    lwbpc_slot_table u_slot_table (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .req           (req_reg),
        .reserved_page (reserved_page_reg),
        .page_limit    (page_limit_reg),
        .result        (result)
    );

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_reg.status;
    assign rsp.slot           = rsp_reg.slot;
    assign rsp.writeback      = rsp_reg.writeback;
    assign rsp.writeback_page = rsp_reg.writeback_page;
    assign rsp.fill           = rsp_reg.fill;
    assign rsp.last           = rsp_reg.last;

    `LWBPC_ASSERT_NEXT(a_flush_holds_request, req_valid_reg && !req_done,
        req_valid_reg && $stable(req_reg), "request left before its last word")
    `LWBPC_ASSERT_NOW(a_fill_only_on_miss, rsp_valid_reg && rsp_reg.fill,
        rsp_reg.status == ST_MISS, "fill without a miss")
    `LWBPC_ASSERT_NOW(a_wb_page_zero, rsp_valid_reg && !rsp_reg.writeback,
        rsp_reg.writeback_page == '0, "writeback page set without writeback")

endmodule

// File: design/lwbpc_slot_table.sv
`timescale 1ns / 1ps
`include "lru_write_back_page_cache_assert.svh"

module lwbpc_slot_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  lwbpc_pkg::req_t   req,
    input  lwbpc_pkg::page_t  reserved_page,
    input  lwbpc_pkg::page_t  page_limit,
    output lwbpc_pkg::rsp_t   result
);
    import lwbpc_pkg::*;

    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    logic [SLOTS-1:0] dirty_reg;
    logic [SLOTS-1:0] dirty_next;
    page_t            page_reg  [SLOTS];
    page_t            page_next [SLOTS];
    slot_idx_t        rank_reg  [SLOTS];
    slot_idx_t        rank_next [SLOTS];

    logic [SLOTS-1:0] hit_vec;
    logic [SLOTS-1:0] flush_vec;
    logic [SLOTS-1:0] rank_seen;
    logic             hit;
    logic             any_invalid;
    logic             flush_any;
    logic             flush_more;
    slot_idx_t        hit_idx;
    slot_idx_t        inv_idx;
    slot_idx_t        lru_idx;
    slot_idx_t        flush_idx;
    slot_idx_t        victim_idx;
    slot_idx_t        sel_idx;

    // Parallel tag compare and priority pickers; the lowest slot wins each search.
    always_comb
    begin
        hit_idx    = '0;
        inv_idx    = '0;
        lru_idx    = '0;
        flush_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            hit_vec[i]   = valid_reg[i] && (page_reg[i] == req.page_id);
            flush_vec[i] = valid_reg[i] && dirty_reg[i];
            if (hit_vec[i])
            begin
                hit_idx = SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                inv_idx = SLOT_W'(i);
            end
            if (rank_reg[i] == '0)
            begin
                lru_idx = SLOT_W'(i);
            end
            if (flush_vec[i])
            begin
                flush_idx = SLOT_W'(i);
            end
        end
        hit         = |hit_vec;
        any_invalid = ~&valid_reg;
        flush_any   = |flush_vec;
        flush_more  = |(flush_vec & ~(SLOTS'(1) << flush_idx));
        victim_idx  = any_invalid ? inv_idx : lru_idx;
        sel_idx     = hit ? hit_idx : victim_idx;
    end

    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        for (int i = 0; i < SLOTS; i++)
        begin
            page_next[i] = page_reg[i];
            rank_next[i] = rank_reg[i];
        end
        result = '{status: ST_NONE, slot: 1'b0, writeback: 1'b0,
                   writeback_page: '0, fill: 1'b0, last: 1'b1};

        case (req.kind)
            KIND_READ, KIND_WRITE:
            begin
                if (req.kind == KIND_WRITE && req.page_id == reserved_page)
                begin
                    result.status = ST_REJ_RESERVED;
                end
                else if (req.kind == KIND_WRITE && req.page_id >= page_limit)
                begin
                    result.status = ST_REJ_RANGE;
                end
                else
                begin
                    result.slot = sel_idx[0];
                    if (hit)
                    begin
                        result.status = ST_HIT;
                    end
                    else
                    begin
                        result.status    = ST_MISS;
                        result.fill      = 1'b1;
                        result.writeback = valid_reg[sel_idx] && dirty_reg[sel_idx];
                        if (result.writeback)
                        begin
                            result.writeback_page = page_reg[sel_idx];
                        end
                        page_next[sel_idx]  = req.page_id;
                        valid_next[sel_idx] = 1'b1;
                        dirty_next[sel_idx] = 1'b0;
                    end
                    // Move the slot to most recent and close the gap it leaves.
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (rank_reg[i] > rank_reg[sel_idx])
                        begin
                            rank_next[i] = rank_reg[i] - SLOT_W'(1);
                        end
                    end
                    rank_next[sel_idx] = SLOT_W'(SLOTS - 1);
                    if (req.kind == KIND_WRITE)
                    begin
                        dirty_next[sel_idx] = 1'b1;
                    end
                end
            end
            KIND_MARK_DIRTY:
            begin
                if (hit)
                begin
                    result.status       = ST_HIT;
                    result.slot         = hit_idx[0];
                    dirty_next[hit_idx] = 1'b1;
                end
            end
            KIND_FLUSH:
            begin
                // One dirty slot is written back per step; the request stays
                // in place until no dirty slot is left.
                if (flush_any)
                begin
                    result.slot           = flush_idx[0];
                    result.writeback      = 1'b1;
                    result.writeback_page = page_reg[flush_idx];
                    result.last           = !flush_more;
                    dirty_next[flush_idx] = 1'b0;
                end
            end
            default:
            begin
                result.status = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                rank_reg[i] <= SLOT_W'(i);
            end
        end
        else if (step)
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            for (int i = 0; i < SLOTS; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Tags are only looked at while their slot is valid.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                page_reg[i] <= page_next[i];
            end
        end
    end

    always_comb
    begin
        rank_seen = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            rank_seen[rank_reg[i]] = 1'b1;
        end
    end

    `LWBPC_ASSERT_NOW(a_rank_permutation, 1'b1, &rank_seen, "ranks are not a permutation")
    `LWBPC_ASSERT_NOW(a_dirty_needs_valid, 1'b1, (dirty_reg & ~valid_reg) == '0,
        "dirty bit set on an invalid slot")
    `LWBPC_ASSERT_NOW(a_single_hit, 1'b1, $onehot0(hit_vec), "page cached in two slots")

endmodule
